// ----- rtl/yrc_pkg.sv -----
// shared constants, types and helpers of the yuyv to rgb converter
package yrc_pkg;

  // q16 conversion coefficients (full-range bt.601)
  localparam logic [16:0] CoefCrR = 17'd91881;
  localparam logic [16:0] CoefCbG = 17'd22554;
  localparam logic [16:0] CoefCrG = 17'd46802;
  localparam logic [16:0] CoefCbB = 17'd116130;

  localparam int TermW = 25;  // signed width of one chroma term
  localparam int SumW  = 26;  // signed width of luma plus chroma term
  localparam int FracW = 16;  // fraction bits of the q16 sums

  typedef logic signed [TermW-1:0] term_t;
  typedef logic signed [SumW-1:0]  sum_t;

  // chroma contributions shared by both pixel lanes
  typedef struct packed {
    term_t blue;
    term_t green;
    term_t red;
  } chroma_terms_t;

  // one clamped rgb pixel
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // signed chroma offset times unsigned q16 coefficient
  function automatic term_t coef_mul(input logic signed [7:0] d, input logic [16:0] c);
    logic signed [TermW-1:0] de;
    logic signed [TermW-1:0] ce;
    de = TermW'(d);
    ce = signed'({{(TermW-17){1'b0}}, c});
    return TermW'(de * ce);
  endfunction

endpackage

// ----- rtl/yrc_if.sv -----
// valid/ready channel interfaces for macropixel input and rgb pair output
interface yrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_first;
  logic [7:0] chroma_blue;
  logic [7:0] luma_second;
  logic [7:0] chroma_red;

  modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                  input ready);
  modport sink   (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                  output ready);
endinterface

interface yrc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_first;
  logic [7:0] green_first;
  logic [7:0] red_first;
  logic [7:0] blue_second;
  logic [7:0] green_second;
  logic [7:0] red_second;

  modport source (output valid, blue_first, green_first, red_first,
                  blue_second, green_second, red_second, input ready);
  modport sink   (input valid, blue_first, green_first, red_first,
                  blue_second, green_second, red_second, output ready);
endinterface

// ----- rtl/yuyv_to_rgb_converter_core.sv -----
// an item passes the chroma stage register, then the output register, to its result
// one macropixel per cycle unless out_ch stalls; both pixel lanes work in parallel
// while a result waits, the chroma stage takes one more item, then the input stalls
// reset: synchronous active-low rst_n clears both stage valids; data regs not reset
// no state is kept between items
module yuyv_to_rgb_converter_core (
  input  logic      clk,
  input  logic      rst_n,
  yrc_in_if.sink    in_ch,
  yrc_out_if.source out_ch
);

  logic                   s1_valid;
  logic                   s1_ready;
  yrc_pkg::chroma_terms_t s1_terms;
  logic [7:0]             s1_luma_first;
  logic [7:0]             s1_luma_second;
  yrc_pkg::pixel_t        pixel_first;
  yrc_pkg::pixel_t        pixel_second;

  // shared chroma products
  yrc_chroma u_chroma (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .s1_valid       (s1_valid),
    .s1_ready       (s1_ready),
    .s1_terms       (s1_terms),
    .s1_luma_first  (s1_luma_first),
    .s1_luma_second (s1_luma_second)
  );

  // pixel lanes
  yrc_lane u_lane_first (
    .luma  (s1_luma_first),
    .terms (s1_terms),
    .pixel (pixel_first)
  );

  yrc_lane u_lane_second (
    .luma  (s1_luma_second),
    .terms (s1_terms),
    .pixel (pixel_second)
  );

  // result register
  yrc_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .s1_valid     (s1_valid),
    .s1_ready     (s1_ready),
    .pixel_first  (pixel_first),
    .pixel_second (pixel_second),
    .out_ch       (out_ch)
  );

endmodule

// ----- rtl/yrc_chroma.sv -----
// first stage: shared chroma products, registered with both luma samples
module yrc_chroma (
  input  logic                   clk,
  input  logic                   rst_n,
  yrc_in_if.sink                 in_ch,
  output logic                   s1_valid,
  input  logic                   s1_ready,
  output yrc_pkg::chroma_terms_t s1_terms,
  output logic [7:0]             s1_luma_first,
  output logic [7:0]             s1_luma_second
);

  logic                   valid_r;
  logic                   valid_nxt;
  yrc_pkg::chroma_terms_t terms_r;
  yrc_pkg::chroma_terms_t terms_nxt;
  logic [7:0]             luma_first_r;
  logic [7:0]             luma_second_r;
  logic signed [7:0]      du;
  logic signed [7:0]      dv;
  logic                   take;

  // stage can load when empty or when its content moves on
  assign in_ch.ready = !valid_r || s1_ready;
  assign take        = in_ch.valid && in_ch.ready;

  // offset-128 samples become signed by flipping the top bit
  assign du = signed'(in_ch.chroma_blue ^ 8'h80);
  assign dv = signed'(in_ch.chroma_red ^ 8'h80);

  // chroma products, green pair summed and negated
  always_comb begin
    terms_nxt.blue  = yrc_pkg::coef_mul(du, yrc_pkg::CoefCbB);
    terms_nxt.red   = yrc_pkg::coef_mul(dv, yrc_pkg::CoefCrR);
    terms_nxt.green = -(yrc_pkg::coef_mul(du, yrc_pkg::CoefCbG)
                        + yrc_pkg::coef_mul(dv, yrc_pkg::CoefCrG));
  end

  assign valid_nxt = take ? 1'b1 : (s1_ready ? 1'b0 : valid_r);

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (take) begin
      terms_r       <= terms_nxt;
      luma_first_r  <= in_ch.luma_first;
      luma_second_r <= in_ch.luma_second;
    end
  end

  assign s1_valid       = valid_r;
  assign s1_terms       = terms_r;
  assign s1_luma_first  = luma_first_r;
  assign s1_luma_second = luma_second_r;

endmodule

// ----- rtl/yrc_lane.sv -----
// one pixel lane: adds scaled luma to the chroma terms and clamps each channel
module yrc_lane (
  input  logic [7:0]             luma,
  input  yrc_pkg::chroma_terms_t terms,
  output yrc_pkg::pixel_t        pixel
);

  yrc_pkg::sum_t base;

  // luma scaled to q16, always non-negative
  assign base = signed'({2'b00, luma, {yrc_pkg::FracW{1'b0}}});

  // floor shift and saturate to 0..255
  function automatic logic [7:0] clamp_q16(input yrc_pkg::sum_t s);
    logic [7:0] v;
    if (s[yrc_pkg::SumW-1]) begin
      v = 8'd0;
    end else if (s[yrc_pkg::SumW-2]) begin
      v = 8'hFF;
    end else begin
      v = s[yrc_pkg::FracW+7:yrc_pkg::FracW];
    end
    return v;
  endfunction

  // per-channel sums
  always_comb begin
    pixel.blue  = clamp_q16(base + yrc_pkg::SumW'(terms.blue));
    pixel.green = clamp_q16(base + yrc_pkg::SumW'(terms.green));
    pixel.red   = clamp_q16(base + yrc_pkg::SumW'(terms.red));
  end

endmodule

// ----- rtl/yrc_merge.sv -----
// merge stage: packs both lane pixels into the registered result
module yrc_merge (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            s1_valid,
  output logic            s1_ready,
  input  yrc_pkg::pixel_t pixel_first,
  input  yrc_pkg::pixel_t pixel_second,
  yrc_out_if.source       out_ch
);

  logic            valid_r;
  logic            valid_nxt;
  yrc_pkg::pixel_t first_r;
  yrc_pkg::pixel_t second_r;
  logic            take;

  // output register loads when empty or being drained
  assign s1_ready  = !valid_r || out_ch.ready;
  assign take      = s1_valid && s1_ready;
  assign valid_nxt = take ? 1'b1 : (out_ch.ready ? 1'b0 : valid_r);

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      first_r  <= pixel_first;
      second_r <= pixel_second;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.blue_first   = first_r.blue;
  assign out_ch.green_first  = first_r.green;
  assign out_ch.red_first    = first_r.red;
  assign out_ch.blue_second  = second_r.blue;
  assign out_ch.green_second = second_r.green;
  assign out_ch.red_second   = second_r.red;

endmodule
